### src/slbc_pkg.sv
package slbc_pkg;

    localparam int CFG_DATA_W  = 64;
    localparam int CFG_INDEX_W = 3;
    localparam int STEPS_W     = 3;

    typedef enum logic [2:0] {
        MODE_TICK     = 3'd0,
        MODE_LOCALIZE = 3'd1,
        MODE_ROUTE    = 3'd2,
        MODE_HAZARD   = 3'd3,
        MODE_OPERATE  = 3'd4,
        MODE_EVALUATE = 3'd5
    } t_mode;

    typedef enum logic [2:0] {
        SVC_NONE      = 3'd0,
        SVC_OTHER     = 3'd1,
        SVC_EMERGENCY = 3'd2,
        SVC_ROUTE     = 3'd3,
        SVC_WAKING    = 3'd4
    } t_service;

    localparam logic [2:0] ROUTE_UNSET    = 3'd1;
    localparam logic [2:0] ROUTE_ARRIVED  = 3'd3;
    localparam logic [2:0] ROUTE_CHANGING = 3'd4;

    localparam logic [1:0] LOC_INITIALIZING = 2'd2;

    localparam logic [CFG_INDEX_W-1:0] REG_FAST_PATTERN = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_SLOW_PATTERN = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_FAST_STEPS   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_SLOW_STEPS   = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_ACTIVE_HIGH  = 3'd4;

    typedef struct packed {
        logic tick;
        logic start;
        logic fast;
        logic hold;
    } t_blink_cmd;

endpackage

### src/slbc_blink.sv
module slbc_blink
    import slbc_pkg::*;
#(
    parameter int MAX_STEPS     = 4,
    parameter int DURATION_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_adv,
    input  t_blink_cmd            i_cmd,
    input  logic [CFG_DATA_W-1:0] i_fast_pattern,
    input  logic [CFG_DATA_W-1:0] i_slow_pattern,
    input  logic [STEPS_W-1:0]    i_fast_steps,
    input  logic [STEPS_W-1:0]    i_slow_steps,
    output logic                  o_lit_next
);

    localparam int IDX_W  = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1;
    localparam int DUR_N  = 1 << IDX_W;
    localparam int CNT_RAW = $clog2(MAX_STEPS + 1);
    localparam int CNT_W  = (CNT_RAW > STEPS_W) ? CNT_RAW : STEPS_W;
    localparam int PAD_W  = CFG_DATA_W + DURATION_BITS;

    logic                     r_on;
    logic                     r_fast;
    logic [IDX_W-1:0]         r_idx;
    logic [DURATION_BITS-1:0] r_ms;
    logic                     r_lit;

    logic                     n_on;
    logic                     n_fast;
    logic [IDX_W-1:0]         n_idx;
    logic [DURATION_BITS-1:0] n_ms;
    logic                     n_lit;

    logic [PAD_W-1:0]         fast_pad;
    logic [PAD_W-1:0]         slow_pad;
    logic [DURATION_BITS-1:0] fast_dur [DUR_N];
    logic [DURATION_BITS-1:0] slow_dur [DUR_N];

    logic [CNT_W-1:0]         steps_raw;
    logic [CNT_W-1:0]         steps_used;
    logic [CNT_W-1:0]         idx_inc;
    logic [IDX_W-1:0]         idx_adv;

    assign fast_pad = {{DURATION_BITS{1'b0}}, i_fast_pattern};
    assign slow_pad = {{DURATION_BITS{1'b0}}, i_slow_pattern};

    for (genvar k = 0; k < DUR_N; k++) begin : g_dur
        if (k < MAX_STEPS && k * DURATION_BITS < CFG_DATA_W) begin : g_field
            assign fast_dur[k] = fast_pad[k*DURATION_BITS +: DURATION_BITS];
            assign slow_dur[k] = slow_pad[k*DURATION_BITS +: DURATION_BITS];
        end else begin : g_zero
            assign fast_dur[k] = '0;
            assign slow_dur[k] = '0;
        end
    end

    always_comb begin
        steps_raw = r_fast ? CNT_W'(i_fast_steps) : CNT_W'(i_slow_steps);
        if (steps_raw == '0) begin
            steps_used = CNT_W'(1);
        end else if (steps_raw > CNT_W'(MAX_STEPS)) begin
            steps_used = CNT_W'(MAX_STEPS);
        end else begin
            steps_used = steps_raw;
        end
        idx_inc = CNT_W'(r_idx) + CNT_W'(1);
        idx_adv = (idx_inc >= steps_used) ? '0 : idx_inc[IDX_W-1:0];
    end

    always_comb begin
        n_on   = r_on;
        n_fast = r_fast;
        n_idx  = r_idx;
        n_ms   = r_ms;
        n_lit  = r_lit;
        if (i_cmd.start) begin
            n_on   = 1'b1;
            n_fast = i_cmd.fast;
            n_idx  = '0;
            n_ms   = i_cmd.fast ? fast_dur[0] : slow_dur[0];
            n_lit  = 1'b0;
        end else if (i_cmd.hold) begin
            n_on  = 1'b0;
            n_lit = 1'b1;
        end else if (i_cmd.tick && r_on) begin
            if (r_ms > DURATION_BITS'(1)) begin
                n_ms = r_ms - DURATION_BITS'(1);
            end else begin
                n_idx = idx_adv;
                n_ms  = r_fast ? fast_dur[idx_adv] : slow_dur[idx_adv];
                n_lit = idx_adv[0];
            end
        end
    end

    assign o_lit_next = n_lit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_on   <= 1'b0;
            r_fast <= 1'b0;
            r_idx  <= '0;
            r_ms   <= '0;
            r_lit  <= 1'b0;
        end else if (i_adv) begin
            r_on   <= n_on;
            r_fast <= n_fast;
            r_idx  <= n_idx;
            r_ms   <= n_ms;
            r_lit  <= n_lit;
        end
    end

endmodule

### src/status_lamp_blink_controller.sv
// The result of an input transfer is registered and shows on the master side in the cycle after it.
// Throughput: one item per cycle while m_axis_tready is high; the result register frees whenever
// m_axis_tready is high, so input and output transfers overlap back to back.
// Each item updates status and blink state through one stage of logic.
// Reset (synchronous, active low): lamp dark, blink stopped, service not evaluated,
// registers at fast/slow steps 2, patterns 0, active high.
module status_lamp_blink_controller
    import slbc_pkg::*;
#(
    parameter int MAX_STEPS     = 4,
    parameter int DURATION_BITS = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // [1:0] localization_state, [4:2] route_state, [5] hazard_hold,
    // [6] control_enabled, [7] stop_mode_available, [8] local_mode_available
    input  logic [15:0]            s_axis_tdata,
    // [2:0] mode
    input  logic [2:0]             s_axis_tuser,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // [0] pin_level, [1] lamp_lit, [4:2] service_state, [5] control_auto
    output logic [7:0]             m_axis_tdata,
    input  logic                   i_cfg_we,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_wdata
);

    logic [CFG_DATA_W-1:0] r_fast_pattern;
    logic [CFG_DATA_W-1:0] r_slow_pattern;
    logic [STEPS_W-1:0]    r_fast_steps;
    logic [STEPS_W-1:0]    r_slow_steps;
    logic                  r_active_high;

    logic [1:0] r_loc;
    logic [2:0] r_route;
    logic       r_hold;
    logic [2:0] r_flags;
    t_service   r_svc;
    logic       r_auto;

    logic [1:0] n_loc;
    logic [2:0] n_route;
    logic       n_hold;
    logic [2:0] n_flags;
    t_service   n_svc;
    logic       n_auto;

    logic       r_out_valid;
    logic [7:0] r_out_data;

    logic       accept;
    t_mode      mode;
    logic       do_eval;
    t_service   eval_svc;
    logic       eval_auto;
    t_blink_cmd cmd;
    logic       lit_next;

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign mode          = t_mode'(s_axis_tuser);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fast_pattern <= '0;
            r_slow_pattern <= '0;
            r_fast_steps   <= STEPS_W'(2);
            r_slow_steps   <= STEPS_W'(2);
            r_active_high  <= 1'b1;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_FAST_PATTERN: r_fast_pattern <= i_cfg_wdata;
                REG_SLOW_PATTERN: r_slow_pattern <= i_cfg_wdata;
                REG_FAST_STEPS:   r_fast_steps   <= i_cfg_wdata[STEPS_W-1:0];
                REG_SLOW_STEPS:   r_slow_steps   <= i_cfg_wdata[STEPS_W-1:0];
                REG_ACTIVE_HIGH:  r_active_high  <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        n_loc   = r_loc;
        n_route = r_route;
        n_hold  = r_hold;
        n_flags = r_flags;
        do_eval = 1'b0;
        case (mode)
            MODE_LOCALIZE: begin
                n_loc   = s_axis_tdata[1:0];
                do_eval = 1'b1;
            end
            MODE_ROUTE: begin
                n_route = s_axis_tdata[4:2];
                do_eval = 1'b1;
            end
            MODE_HAZARD: begin
                n_hold  = s_axis_tdata[5];
                do_eval = 1'b1;
            end
            MODE_OPERATE: begin
                n_flags = {s_axis_tdata[8], s_axis_tdata[7], s_axis_tdata[6]};
                do_eval = 1'b1;
            end
            MODE_EVALUATE: do_eval = 1'b1;
            default: ;
        endcase

        if (n_hold) begin
            eval_svc = SVC_EMERGENCY;
        end else if (n_route == ROUTE_UNSET || n_route == ROUTE_ARRIVED ||
                     n_route == ROUTE_CHANGING) begin
            eval_svc = SVC_ROUTE;
        end else if (n_loc == LOC_INITIALIZING && n_flags[2:1] != 2'b00) begin
            eval_svc = SVC_WAKING;
        end else begin
            eval_svc = SVC_OTHER;
        end
        eval_auto = n_flags[0];

        cmd.tick  = (mode == MODE_TICK);
        cmd.start = 1'b0;
        cmd.fast  = 1'b0;
        cmd.hold  = 1'b0;
        n_svc     = r_svc;
        n_auto    = r_auto;
        if (do_eval && (eval_svc != r_svc || eval_auto != r_auto)) begin
            n_svc  = eval_svc;
            n_auto = eval_auto;
            case (eval_svc)
                SVC_WAKING: cmd.start = 1'b1;
                SVC_ROUTE: begin
                    cmd.start = 1'b1;
                    cmd.fast  = 1'b1;
                end
                SVC_EMERGENCY: cmd.hold = 1'b1;
                default: begin
                    if (eval_auto) begin
                        cmd.hold = 1'b1;
                    end else begin
                        cmd.start = 1'b1;
                        cmd.fast  = 1'b1;
                    end
                end
            endcase
        end
    end

    slbc_blink #(
        .MAX_STEPS     (MAX_STEPS),
        .DURATION_BITS (DURATION_BITS)
    ) u_blink (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_adv          (accept),
        .i_cmd          (cmd),
        .i_fast_pattern (r_fast_pattern),
        .i_slow_pattern (r_slow_pattern),
        .i_fast_steps   (r_fast_steps),
        .i_slow_steps   (r_slow_steps),
        .o_lit_next     (lit_next)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_loc   <= '0;
            r_route <= '0;
            r_hold  <= 1'b0;
            r_flags <= '0;
            r_svc   <= SVC_NONE;
            r_auto  <= 1'b0;
        end else if (accept) begin
            r_loc   <= n_loc;
            r_route <= n_route;
            r_hold  <= n_hold;
            r_flags <= n_flags;
            r_svc   <= n_svc;
            r_auto  <= n_auto;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out_data <= {2'b00, n_auto, n_svc, lit_next, lit_next ^ ~r_active_high};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule
